// ===== rtl/uam_pkg.sv =====
// Package: shared types, frame constants and checksum helpers for the ack matcher.
`timescale 1ns / 1ps
`default_nettype none
package uam_pkg;

	localparam int unsigned FRAME_LEN = 10;
	localparam logic [15:0] TIMEOUT_RESET = 16'd3000;

	localparam logic [7:0] SYNC_1 = 8'hB5;
	localparam logic [7:0] SYNC_2 = 8'h62;
	localparam logic [7:0] ACK_CLASS = 8'h05;
	localparam logic [7:0] ACK_ID = 8'h01;
	localparam logic [7:0] ACK_LEN_LO = 8'h02;
	localparam logic [7:0] ACK_LEN_HI = 8'h00;

	typedef enum logic [1:0] {
		FUNC_START = 2'd0,
		FUNC_BYTE  = 2'd1,
		FUNC_TICK  = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		STAT_WAIT    = 2'd0,
		STAT_ACKED   = 2'd1,
		STAT_TIMEOUT = 2'd2,
		STAT_IDLE    = 2'd3
	} status_t;

	typedef struct packed {
		func_t      func;
		logic [7:0] msg_class;
		logic [7:0] msg_ident;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		status_t    status;
		logic [3:0] match_count;
	} result_t;

	// Fletcher-8 A sum over bytes 2..7 of the ack frame
	function automatic logic [7:0] ck_a(input logic [7:0] cls, input logic [7:0] ident);
		ck_a = ACK_CLASS + ACK_ID + ACK_LEN_LO + ACK_LEN_HI + cls + ident;
	endfunction

	// Fletcher-8 B sum: running total of the A partial sums
	function automatic logic [7:0] ck_b(input logic [7:0] cls, input logic [7:0] ident);
		logic [7:0] a2, a3, a4, a5;
		a2 = ACK_CLASS + ACK_ID;
		a3 = a2 + ACK_LEN_LO;
		a4 = a3 + ACK_LEN_HI;
		a5 = a4 + cls;
		ck_b = ACK_CLASS + a2 + a3 + a4 + a5 + (a5 + ident);
	endfunction

	function automatic logic [7:0] frame_byte(
		input logic [3:0] pos,
		input logic [7:0] cls,
		input logic [7:0] ident,
		input logic [7:0] ca,
		input logic [7:0] cb
	);
		unique case (pos)
			4'd0:    frame_byte = SYNC_1;
			4'd1:    frame_byte = SYNC_2;
			4'd2:    frame_byte = ACK_CLASS;
			4'd3:    frame_byte = ACK_ID;
			4'd4:    frame_byte = ACK_LEN_LO;
			4'd5:    frame_byte = ACK_LEN_HI;
			4'd6:    frame_byte = cls;
			4'd7:    frame_byte = ident;
			4'd8:    frame_byte = ca;
			default: frame_byte = cb;
		endcase
	endfunction

endpackage
`default_nettype wire

// ===== rtl/uam_core.sv =====
// Matcher state, timeout register and per-request next-state logic.
`timescale 1ns / 1ps
`default_nettype none
module uam_core #(
	parameter logic [15:0] TimeoutReset = uam_pkg::TIMEOUT_RESET
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [15:0]      cfg_wdata,
	input  wire logic             en,
	input  wire uam_pkg::item_t   item,
	output uam_pkg::result_t      result
);

	localparam logic [3:0] FrameLen = 4'(uam_pkg::FRAME_LEN);

	logic [15:0] timeout_q;
	logic [7:0]  cls_q, ident_q, ca_q, cb_q;
	logic [3:0]  pos_q, pos_d;
	logic [15:0] elapsed_q, elapsed_d;
	logic        waiting_q, waiting_d;
	logic [7:0]  exp_byte;
	logic [3:0]  pos_inc;

	assign exp_byte = uam_pkg::frame_byte(pos_q, cls_q, ident_q, ca_q, cb_q);
	assign pos_inc = pos_q + 4'd1;

	always_comb begin
		pos_d = pos_q;
		elapsed_d = elapsed_q;
		waiting_d = waiting_q;
		result.status = uam_pkg::STAT_WAIT;
		if (item.func == uam_pkg::FUNC_START) begin
			pos_d = '0;
			elapsed_d = '0;
			waiting_d = 1'b1;
		end else if (!waiting_q) begin
			result.status = uam_pkg::STAT_IDLE;
		end else begin
			unique case (item.func)
				uam_pkg::FUNC_BYTE: begin
					if (pos_q < FrameLen && item.rx_byte == exp_byte) begin
						pos_d = pos_inc;
					end else begin
						pos_d = '0;
					end
					if (pos_d >= FrameLen) begin
						waiting_d = 1'b0;
						result.status = uam_pkg::STAT_ACKED;
					end
				end
				uam_pkg::FUNC_TICK: begin
					if (elapsed_q != 16'hFFFF) begin
						elapsed_d = elapsed_q + 16'd1;
					end
					if (elapsed_d > timeout_q) begin
						waiting_d = 1'b0;
						result.status = uam_pkg::STAT_TIMEOUT;
					end
				end
				default: begin
				end
			endcase
		end
		result.match_count = pos_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TimeoutReset;
		end else if (cfg_we) begin
			timeout_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cls_q <= '0;
			ident_q <= '0;
			ca_q <= '0;
			cb_q <= '0;
			pos_q <= '0;
			elapsed_q <= '0;
			waiting_q <= 1'b0;
		end else if (en) begin
			pos_q <= pos_d;
			elapsed_q <= elapsed_d;
			waiting_q <= waiting_d;
			if (item.func == uam_pkg::FUNC_START) begin
				cls_q <= item.msg_class;
				ident_q <= item.msg_ident;
				ca_q <= uam_pkg::ck_a(item.msg_class, item.msg_ident);
				cb_q <= uam_pkg::ck_b(item.msg_class, item.msg_ident);
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/ubx_ack_matcher.sv =====
// Top level: input register, matcher core and result register.
// A request is held in the input register; its result is then registered and presented on the master side.
// Throughput: one request per cycle while the master side does not stall; the core updates
// its state in a single pass between the input register and the result register.
// Reset (arst_n low, asynchronous): idle, match position and elapsed count
// cleared, timeout limit back to 3000 ms, both stages empty.
`timescale 1ns / 1ps
`default_nettype none
module ubx_ack_matcher #(
	parameter logic [15:0] TimeoutReset = uam_pkg::TIMEOUT_RESET
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,   // timeout_ms
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,     // msg_class, msg_ident, rx_byte
	input  wire logic [1:0]  s_tuser,     // func
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,     // match_count, zero pad
	output logic [1:0]       m_tuser      // status
);

	logic              valid_s1;
	uam_pkg::item_t    item_s1;
	logic              out_valid_q;
	uam_pkg::result_t  res_d, res_q;
	logic              advance, en;

	assign advance = !out_valid_q || m_tready;
	assign en = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.func <= uam_pkg::func_t'(s_tuser);
			item_s1.msg_class <= s_tdata[7:0];
			item_s1.msg_ident <= s_tdata[15:8];
			item_s1.rx_byte <= s_tdata[23:16];
		end
	end

	uam_core #(
		.TimeoutReset(TimeoutReset)
	) u_core (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.en(en),
		.item(item_s1),
		.result(res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= res_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {4'd0, res_q.match_count};
	assign m_tuser = res_q.status;

endmodule
`default_nettype wire
